@@ rtl/core/tmrt_pkg.sv @@
// shared types, constants and codes for the tiered memory reservation table
`default_nettype none

package tmrt_pkg;

  // fixed field widths of the transfer payload
  localparam int KEY_FIELD_W = 32;
  localparam int TIER_W      = 3;
  localparam int BYTES_W     = 64;
  localparam int MAX_ENT_W   = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // default sizing
  localparam int ENTRIES_DEF  = 64;
  localparam int TIERS_DEF    = 5;
  localparam int KEY_BITS_DEF = 32;

  // operation codes
  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // register indexes: capacities sit below CFG_NUM_CAP, then max entries
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CAP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 3'd5;

  localparam logic [MAX_ENT_W-1:0] MAX_ENT_RESET = 7'd64;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_COMMIT,
    S_REPORT,
    S_DONE
  } tmrt_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic clear_wr;
    logic scan;
    logic check;
    logic commit;
    logic report;
  } tmrt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_last;
  } tmrt_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/tmrt_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module tmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/tmrt_ctrl.sv @@
// controller state machine: clearing pass, table scan and update sequence
`default_nettype none

module tmrt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output      logic                busy,
  output      logic                done,
  output      tmrt_pkg::tmrt_cmd_t cmd,
  input  wire tmrt_pkg::tmrt_sts_t sts
);

  import tmrt_pkg::*;

  tmrt_state_t state;
  tmrt_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.idx_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.idx_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        busy = 1'b0;
        done = 1'b1;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/tmrt_dp.sv @@
// datapath: entry table, tier totals, capacities and result registers
`default_nettype none

module tmrt_dp #(
  parameter int ENTRIES  = tmrt_pkg::ENTRIES_DEF,
  parameter int TIERS    = tmrt_pkg::TIERS_DEF,
  parameter int KEY_BITS = tmrt_pkg::KEY_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tmrt_pkg::tmrt_cmd_t                cmd,
  output      tmrt_pkg::tmrt_sts_t                sts,
  input  wire logic                               cfg_we,
  input  wire logic [tmrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tmrt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               operation,
  input  wire logic [tmrt_pkg::KEY_FIELD_W-1:0]   key,
  input  wire logic [tmrt_pkg::TIER_W-1:0]        tier,
  input  wire logic [tmrt_pkg::BYTES_W-1:0]       request_bytes,
  output      logic                               ok,
  output      logic [tmrt_pkg::BYTES_W-1:0]       tier_reserved,
  output      logic [tmrt_pkg::BYTES_W-1:0]       tier_available,
  output      logic [tmrt_pkg::MAX_ENT_W-1:0]     entry_count
);

  import tmrt_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TW = (TIERS > 1) ? $clog2(TIERS) : 1;
  localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int CW = (LW > MAX_ENT_W) ? LW : MAX_ENT_W;
  localparam int DW = 1 + KW + TIER_W + BYTES_W;
  localparam logic [TIER_W:0]    TIERS_T = (TIER_W + 1)'(TIERS);
  localparam logic [CFG_IDX_W:0] TIERS_C = (CFG_IDX_W + 1)'(TIERS);

  // latched request
  logic               op_r;
  logic [KW-1:0]      key_r;
  logic [TIER_W-1:0]  tier_r;
  logic [BYTES_W-1:0] bytes_r;

  // scan state
  logic [AW-1:0]      idx;
  logic               chk_vld;
  logic               found;
  logic [AW-1:0]      m_idx;
  logic [TIER_W-1:0]  m_tier;
  logic [BYTES_W-1:0] m_bytes;
  logic               free_found;
  logic [AW-1:0]      f_idx;

  // tier state and configuration
  logic [BYTES_W-1:0]   total [TIERS];
  logic [BYTES_W-1:0]   cap   [TIERS];
  logic [MAX_ENT_W-1:0] max_ent;
  logic [LW-1:0]        live;
  logic [BYTES_W-1:0]   avail_r;

  // table memory
  logic          ram_we;
  logic [AW-1:0] ram_wa;
  logic [DW-1:0] ram_wd;
  logic [DW-1:0] rd_data;

  logic               rd_valid;
  logic [KW-1:0]      rd_key;
  logic [TIER_W-1:0]  rd_tier;
  logic [BYTES_W-1:0] rd_bytes;
  logic               hit;

  logic               tier_ok;
  logic               m_tier_ok;
  logic               rel_upd;
  logic [TW-1:0]      tsel;
  logic [TW-1:0]      rsel;
  logic               rsel_ok;
  logic [BYTES_W-1:0] tot_rd;
  logic [BYTES_W-1:0] cap_rd;
  logic               live_lt_max;
  logic               reserve_ok;
  logic               release_ok;
  logic               accept;

  tmrt_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (idx),
    .rdata (rd_data)
  );

  // entry word fields
  assign rd_valid = rd_data[DW-1];
  assign rd_key   = rd_data[DW-2 -: KW];
  assign rd_tier  = rd_data[BYTES_W +: TIER_W];
  assign rd_bytes = rd_data[BYTES_W-1:0];
  assign hit      = chk_vld && rd_valid && (rd_key == key_r);

  assign sts.idx_last = (idx == AW'(ENTRIES - 1));

  // tier selection, one read index for the totals
  assign tier_ok   = ({1'b0, tier_r} < TIERS_T);
  assign m_tier_ok = ({1'b0, m_tier} < TIERS_T);
  assign rel_upd   = cmd.commit && (op_r == OP_RELEASE);
  assign tsel      = tier_r[TW-1:0];
  assign rsel      = rel_upd ? m_tier[TW-1:0] : tsel;
  assign rsel_ok   = rel_upd ? m_tier_ok : tier_ok;
  assign tot_rd    = rsel_ok ? total[rsel] : '0;
  assign cap_rd    = tier_ok ? cap[tsel] : '0;

  // accept decision
  assign live_lt_max = (CW'(live) < CW'(max_ent));
  assign reserve_ok  = (op_r == OP_RESERVE) && (key_r != '0) && (bytes_r != '0) && tier_ok
                       && !found && !(bytes_r > avail_r) && live_lt_max && free_found;
  assign release_ok  = (op_r == OP_RELEASE) && (key_r != '0) && found;
  assign accept      = reserve_ok || release_ok;

  // table write port: clearing pass, new entry or freed entry
  assign ram_we = cmd.clear_wr || (cmd.commit && accept);
  assign ram_wa = cmd.clear_wr ? idx : (reserve_ok ? f_idx : m_idx);
  assign ram_wd = (cmd.commit && reserve_ok) ? {1'b1, key_r, tier_r, bytes_r} : '0;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= operation;
      key_r   <= key[KW-1:0];
      tier_r  <= tier;
      bytes_r <= request_bytes;
    end
  end

  // address counter for clearing and scanning
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      chk_vld <= 1'b0;
    end else begin
      chk_vld <= cmd.scan;
      if (cmd.latch) begin
        idx <= '0;
      end else if (cmd.clear_wr || cmd.scan) begin
        idx <= idx + AW'(1);
      end
    end
  end

  // first key match and first free slot over the scan
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (chk_vld) begin
      if (hit && !found) begin
        found   <= 1'b1;
        m_idx   <= idx - AW'(1);
        m_tier  <= rd_tier;
        m_bytes <= rd_bytes;
      end
      if (!rd_valid && !free_found) begin
        free_found <= 1'b1;
        f_idx      <= idx - AW'(1);
      end
    end
  end

  // headroom of the requested tier
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      avail_r <= cap_rd - tot_rd;
    end
  end

  // reserved totals and live count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TIERS; i++) begin
        total[i] <= '0;
      end
      live <= '0;
    end else if (cmd.commit) begin
      if (reserve_ok) begin
        total[tsel] <= tot_rd + bytes_r;
        live        <= live + LW'(1);
      end else if (release_ok) begin
        if (m_tier_ok) begin
          total[rsel] <= tot_rd - m_bytes;
        end
        if (live != '0) begin
          live <= live - LW'(1);
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TIERS; i++) begin
        cap[i] <= '0;
      end
      max_ent <= MAX_ENT_RESET;
    end else if (cfg_we) begin
      if ((cfg_index < CFG_NUM_CAP) && ({1'b0, cfg_index} < TIERS_C)) begin
        cap[cfg_index[TW-1:0]] <= cfg_data;
      end else if (cfg_index == CFG_MAX_ENTRIES) begin
        max_ent <= cfg_data[MAX_ENT_W-1:0];
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok <= accept;
    end
    if (cmd.report) begin
      tier_reserved  <= tot_rd;
      tier_available <= cap_rd - tot_rd;
      entry_count    <= MAX_ENT_W'(live);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tiered_memory_reservation_table_core.sv @@
// top level of the tiered memory reservation table
//
// Keeps up to ENTRIES named reservations spread over TIERS memory tiers.
// Command channel: a request (operation, key, tier, request_bytes) is taken
// at a clock edge with start high and busy low. One result (ok,
// tier_reserved, tier_available, entry_count) follows, shown for exactly
// one cycle while done is high; the receiver cannot stall it.
// Processing: a key and free slot scan reads one table entry a cycle from
// a single read port memory, followed by check, update and report steps.
// A new request may be started in the done cycle.
// Configuration: cfg_valid/cfg_ready with a register index and 64 bit data;
// cfg_ready is always high. Indexes 0 to 4 are tier capacities, 5 is the
// entry limit; other indexes are ignored. Write only while idle.
// Reset: synchronous, active high. Capacities clear, the entry limit goes
// to 64, totals and count clear, then a clearing pass empties the table
// while busy stays high.
`default_nettype none

module tiered_memory_reservation_table_core #(
  parameter int ENTRIES  = tmrt_pkg::ENTRIES_DEF,
  parameter int TIERS    = tmrt_pkg::TIERS_DEF,
  parameter int KEY_BITS = tmrt_pkg::KEY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic                             operation,
  input  wire logic [tmrt_pkg::KEY_FIELD_W-1:0] key,
  input  wire logic [tmrt_pkg::TIER_W-1:0]      tier,
  input  wire logic [tmrt_pkg::BYTES_W-1:0]     request_bytes,
  output      logic                             done,
  output      logic                             ok,
  output      logic [tmrt_pkg::BYTES_W-1:0]     tier_reserved,
  output      logic [tmrt_pkg::BYTES_W-1:0]     tier_available,
  output      logic [tmrt_pkg::MAX_ENT_W-1:0]   entry_count,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [tmrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tmrt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import tmrt_pkg::*;

  tmrt_cmd_t cmd;
  tmrt_sts_t sts;

  // configuration transfers are always taken
  assign cfg_ready = 1'b1;

  tmrt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  tmrt_dp #(
    .ENTRIES  (ENTRIES),
    .TIERS    (TIERS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .key            (key),
    .tier           (tier),
    .request_bytes  (request_bytes),
    .ok             (ok),
    .tier_reserved  (tier_reserved),
    .tier_available (tier_available),
    .entry_count    (entry_count)
  );

endmodule

`default_nettype wire

@@ rtl/core/tmrt_checker.sv @@
// port level checker for the reservation table core, with its bind
`default_nettype none

module tmrt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);

  // a result is shown only while a new request may be taken
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // an accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("not busy after request transfer");

  // no result right after a request transfer
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> !done)
    else $error("done too early after request transfer");

  // each result is a single cycle pulse
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // configuration transfers are never refused
  assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration transfer refused");

endmodule

bind tiered_memory_reservation_table_core tmrt_checker u_tmrt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

@@ bench/tiered_memory_reservation_table_core_tb.sv @@
// self-checking testbench for the tiered memory reservation table core
module tiered_memory_reservation_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmrt_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEF;
  localparam int NUM_TIERS   = TIERS_DEF;
  localparam int KEY_POOL    = 80;
  localparam int NUM_PHASES  = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;
  localparam logic [BYTES_W-1:0] ALL_ONES = '1;

  // register indexes of the tier capacities and two unused slots
  localparam logic [CFG_IDX_W-1:0] CFG_TIER0_CAP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIER1_CAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIER2_CAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIER3_CAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIER4_CAP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED6   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED7   = 3'd7;

  typedef struct packed {
    logic                   op;
    logic [KEY_FIELD_W-1:0] key;
    logic [TIER_W-1:0]      tier;
    logic [BYTES_W-1:0]     bytes;
  } request_t;

  typedef struct packed {
    logic                 ok;
    logic [BYTES_W-1:0]   reserved;
    logic [BYTES_W-1:0]   available;
    logic [MAX_ENT_W-1:0] count;
  } status_t;

  typedef enum logic {ROW_REG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    request_t                rq;
    bit                      known;
    status_t                 want;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
  } step_row_t;

  // dut ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   operation = OP_RESERVE;
  logic [KEY_FIELD_W-1:0] key = '0;
  logic [TIER_W-1:0]      tier = '0;
  logic [BYTES_W-1:0]     request_bytes = '0;
  logic                   done;
  logic                   ok;
  logic [BYTES_W-1:0]     tier_reserved;
  logic [BYTES_W-1:0]     tier_available;
  logic [MAX_ENT_W-1:0]   entry_count;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // shadow of the table, the totals and the registers
  logic [BYTES_W-1:0]     tier_capacity [NUM_TIERS];
  logic [MAX_ENT_W-1:0]   entry_limit;
  bit                     slot_live     [ENTRIES];
  logic [KEY_FIELD_W-1:0] slot_key      [ENTRIES];
  logic [TIER_W-1:0]      slot_tier     [ENTRIES];
  logic [BYTES_W-1:0]     slot_bytes    [ENTRIES];
  logic [BYTES_W-1:0]     tier_total    [NUM_TIERS];
  logic [MAX_ENT_W-1:0]   live_entries;

  status_t                status_due[$];
  step_row_t              script[$];
  logic [KEY_FIELD_W-1:0] key_pool [KEY_POOL];
  int                     mismatches = 0;
  int                     stall_cycles = 0;

  tiered_memory_reservation_table_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .key            (key),
    .tier           (tier),
    .request_bytes  (request_bytes),
    .done           (done),
    .ok             (ok),
    .tier_reserved  (tier_reserved),
    .tier_available (tier_available),
    .entry_count    (entry_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // register write on the shadow copy
  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    if (idx < CFG_NUM_CAP) begin
      if (idx < NUM_TIERS) tier_capacity[idx] = val;
    end else if (idx == CFG_MAX_ENTRIES) begin
      entry_limit = val[MAX_ENT_W-1:0];
    end
  endfunction

  // apply one request to the shadow table and return the status it reports
  function automatic status_t settle_request(input request_t rq);
    status_t s;
    int i;
    int hit;
    int free_slot;
    s = '0;
    hit = -1;
    free_slot = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_live[i] && slot_key[i] == rq.key) hit = i;
      if (free_slot < 0 && !slot_live[i]) free_slot = i;
    end
    if (rq.op == OP_RESERVE) begin
      if (rq.key != '0 && rq.bytes != '0 && rq.tier < NUM_TIERS && hit < 0) begin
        if (rq.bytes <= tier_capacity[rq.tier] - tier_total[rq.tier] &&
            live_entries < entry_limit && free_slot >= 0) begin
          slot_live[free_slot]  = 1'b1;
          slot_key[free_slot]   = rq.key;
          slot_tier[free_slot]  = rq.tier;
          slot_bytes[free_slot] = rq.bytes;
          tier_total[rq.tier]   = tier_total[rq.tier] + rq.bytes;
          live_entries++;
          s.ok = 1'b1;
        end
      end
    end else if (rq.key != '0 && hit >= 0) begin
      // refund goes to the tier stored with the entry
      tier_total[slot_tier[hit]] = tier_total[slot_tier[hit]] - slot_bytes[hit];
      slot_live[hit] = 1'b0;
      live_entries--;
      s.ok = 1'b1;
    end
    if (rq.tier < NUM_TIERS) begin
      s.reserved  = tier_total[rq.tier];
      s.available = tier_capacity[rq.tier] - tier_total[rq.tier];
    end
    s.count = live_entries;
    return s;
  endfunction

  function automatic step_row_t put_reg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    step_row_t r;
    r.kind    = ROW_REG;
    r.rq      = '0;
    r.known   = 1'b0;
    r.want    = '0;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic step_row_t ask(input logic op, input logic [KEY_FIELD_W-1:0] k,
                                    input logic [TIER_W-1:0] t,
                                    input logic [BYTES_W-1:0] b);
    step_row_t r;
    r.kind    = ROW_REQ;
    r.rq      = '{op: op, key: k, tier: t, bytes: b};
    r.known   = 1'b0;
    r.want    = '0;
    r.reg_idx = '0;
    r.reg_val = '0;
    return r;
  endfunction

  function automatic step_row_t ask_known(input logic op, input logic [KEY_FIELD_W-1:0] k,
                                          input logic [TIER_W-1:0] t,
                                          input logic [BYTES_W-1:0] b, input logic w_ok,
                                          input logic [BYTES_W-1:0] w_res,
                                          input logic [BYTES_W-1:0] w_avail,
                                          input logic [MAX_ENT_W-1:0] w_cnt);
    step_row_t r;
    r       = ask(op, k, t, b);
    r.known = 1'b1;
    r.want  = '{ok: w_ok, reserved: w_res, available: w_avail, count: w_cnt};
    return r;
  endfunction

  // append one row to the directed script
  function automatic void add_row(input step_row_t r);
    script.insert(script.size(), r);
  endfunction

  function automatic logic [BYTES_W-1:0] pick_capacity();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return ALL_ONES;
      4: return {$urandom, $urandom};
      default: return 64'($urandom_range(500, 20000));
    endcase
  endfunction

  // mostly well-formed traffic on a pool of keys, some pure noise
  function automatic request_t pick_request(input int reserve_pct);
    request_t rq;
    if ($urandom_range(0, 99) < 12) begin
      rq.op    = $urandom_range(0, 1) ? OP_RELEASE : OP_RESERVE;
      rq.key   = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
      rq.tier  = TIER_W'($urandom_range(0, 7));
      rq.bytes = {$urandom, $urandom};
    end else begin
      rq.op   = ($urandom_range(0, 99) < reserve_pct) ? OP_RESERVE : OP_RELEASE;
      rq.key  = key_pool[$urandom_range(0, KEY_POOL - 1)];
      rq.tier = TIER_W'($urandom_range(0, NUM_TIERS - 1));
      if (rq.op == OP_RELEASE || $urandom_range(0, 9) == 0) rq.bytes = {$urandom, $urandom};
      else rq.bytes = 64'($urandom_range(1, 400));
    end
    return rq;
  endfunction

  // present a request until the block takes it, then book its status
  task automatic issue(input request_t rq, input bit known, input status_t want);
    status_t s;
    start         <= 1'b1;
    operation     <= rq.op;
    key           <= rq.key;
    tier          <= rq.tier;
    request_bytes <= rq.bytes;
    do @(posedge clk); while (busy !== 1'b0);
    s = settle_request(rq);
    status_due.insert(status_due.size(), known ? want : s);
  endtask

  // one register transfer, valid dropped again right after
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    set_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every booked status has come back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0 || busy !== 1'b0);
  endtask

  // result checker
  always @(posedge clk) begin
    status_t want;
    if (!rst && done === 1'b1) begin
      if (status_due.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = status_due.pop_front();
        if (ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok);
          mismatches++;
        end
        if (tier_reserved !== want.reserved) begin
          $error("tier_reserved: expected %h, got %h", want.reserved, tier_reserved);
          mismatches++;
        end
        if (tier_available !== want.available) begin
          $error("tier_available: expected %h, got %h", want.available, tier_available);
          mismatches++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** tiered_memory_reservation_table_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int ph;
    int n;
    int j;
    int burst;
    int gap;
    int lim;
    int pct;
    int t;
    foreach (tier_capacity[i]) tier_capacity[i] = '0;
    foreach (tier_total[i]) tier_total[i] = '0;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    entry_limit  = MAX_ENT_RESET;
    live_entries = '0;
    for (j = 0; j < KEY_POOL; j++) begin
      do key_pool[j] = $urandom; while (key_pool[j] == '0);
    end

    // directed script: rejection cases, extremes, refunds and wrap-around
    add_row(put_reg(CFG_TIER0_CAP, 64'd1000));
    add_row(put_reg(CFG_TIER1_CAP, ALL_ONES));
    add_row(put_reg(CFG_TIER2_CAP, 64'd0));
    add_row(put_reg(CFG_TIER3_CAP, 64'd500));
    add_row(put_reg(CFG_TIER4_CAP, 64'd1));
    add_row(put_reg(CFG_MAX_ENTRIES, 64'd64));
    add_row(put_reg(CFG_UNUSED6, 64'd123));
    add_row(put_reg(CFG_UNUSED7, ALL_ONES));
    // empty key, zero bytes, invalid tiers
    add_row(ask_known(OP_RESERVE, 32'd0, 3'd0, 64'd10, 1'b0, 64'd0, 64'd1000, 7'd0));
    add_row(ask_known(OP_RESERVE, 32'd5, 3'd0, 64'd0, 1'b0, 64'd0, 64'd1000, 7'd0));
    add_row(ask_known(OP_RESERVE, 32'd5, 3'd7, 64'd10, 1'b0, 64'd0, 64'd0, 7'd0));
    add_row(ask_known(OP_RESERVE, 32'd5, 3'd5, 64'd10, 1'b0, 64'd0, 64'd0, 7'd0));
    // exact fit, then over capacity, then duplicate key
    add_row(ask_known(OP_RESERVE, 32'd1, 3'd0, 64'd1000, 1'b1, 64'd1000, 64'd0,
                      7'd1));
    add_row(ask_known(OP_RESERVE, 32'd2, 3'd0, 64'd1, 1'b0, 64'd1000, 64'd0, 7'd1));
    add_row(ask_known(OP_RESERVE, 32'd1, 3'd1, 64'd5, 1'b0, 64'd0, ALL_ONES, 7'd1));
    add_row(ask_known(OP_RESERVE, 32'hFFFF_FFFF, 3'd1, ALL_ONES, 1'b1, ALL_ONES,
                      64'd0, 7'd2));
    add_row(ask_known(OP_RESERVE, 32'd3, 3'd2, 64'd1, 1'b0, 64'd0, 64'd0, 7'd2));
    // release of empty key, absent key, and refund to another tier
    add_row(ask_known(OP_RELEASE, 32'd0, 3'd0, 64'd0, 1'b0, 64'd1000, 64'd0, 7'd2));
    add_row(ask_known(OP_RELEASE, 32'd77, 3'd6, 64'd0, 1'b0, 64'd0, 64'd0, 7'd2));
    add_row(ask_known(OP_RELEASE, 32'd1, 3'd3, ALL_ONES, 1'b1, 64'd0, 64'd500,
                      7'd1));
    add_row(ask(OP_RESERVE, 32'd1, 3'd0, 64'd400));
    add_row(ask_known(OP_RESERVE, 32'h8000_0000, 3'd4, 64'd1, 1'b1, 64'd1, 64'd0,
                      7'd3));
    add_row(ask_known(OP_RELEASE, 32'hFFFF_FFFF, 3'd1, 64'd0, 1'b1, 64'd0, ALL_ONES,
                      7'd2));
    add_row(ask_known(OP_RELEASE, 32'hFFFF_FFFF, 3'd1, 64'd0, 1'b0, 64'd0, ALL_ONES,
                      7'd2));
    // entry limit reached, then limit zero
    add_row(put_reg(CFG_MAX_ENTRIES, 64'd2));
    add_row(ask_known(OP_RESERVE, 32'd9, 3'd3, 64'd5, 1'b0, 64'd0, 64'd500, 7'd2));
    add_row(put_reg(CFG_MAX_ENTRIES, 64'd0));
    add_row(ask(OP_RELEASE, 32'd1, 3'd2, 64'd0));
    add_row(ask_known(OP_RESERVE, 32'd9, 3'd3, 64'd5, 1'b0, 64'd0, 64'd500, 7'd1));
    // capacity lowered below the reserved total, totals wrap
    add_row(put_reg(CFG_TIER4_CAP, 64'd0));
    add_row(put_reg(CFG_MAX_ENTRIES, 64'd127));
    add_row(ask_known(OP_RESERVE, 32'd0, 3'd4, 64'd1, 1'b0, 64'd1, ALL_ONES, 7'd1));
    add_row(ask_known(OP_RESERVE, 32'd10, 3'd4, ALL_ONES, 1'b1, 64'd0, 64'd0, 7'd2));
    add_row(ask_known(OP_RELEASE, 32'h8000_0000, 3'd0, 64'd0, 1'b1, 64'd0,
                      64'd1000, 7'd1));
    add_row(ask_known(OP_RELEASE, 32'd10, 3'd4, 64'd0, 1'b1, 64'd0, 64'd0, 7'd0));

    // reset, then wait out the clearing pass
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy !== 1'b0);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        drain();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        issue(script[i].rq, script[i].known, script[i].want);
      end
    end

    // random phases, each under fresh capacities and entry limit
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: lim = 127;
        2: lim = 0;
        3: lim = 1;
        4: lim = $urandom_range(2, 63);
        6: lim = $urandom_range(65, 126);
        default: lim = 64;
      endcase
      for (t = 0; t < NUM_TIERS; t++) begin
        write_reg(CFG_IDX_W'(t), (ph == 0) ? ALL_ONES : pick_capacity());
      end
      write_reg(CFG_MAX_ENTRIES, {$urandom, 25'($urandom), 7'(lim)});
      pct = (ph == 0) ? 90 : (ph == 1) ? 25 : 55;
      n = (ph == 0) ? 200 : 80;
      while (n > 0) begin
        burst = $urandom_range(1, 12);
        for (j = 0; j < burst && n > 0; j++) begin
          issue(pick_request(pct), 1'b0, '0);
          n--;
        end
        // gap after the burst: full drain, long pause, short pause or none
        case ($urandom_range(0, 9))
          0: drain();
          1, 2: begin
            gap = $urandom_range(20, 90);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          3, 4, 5: begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          default: ;
        endcase
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** tiered_memory_reservation_table_core: PASSED **");
    end else begin
      $display("** tiered_memory_reservation_table_core: FAILED **");
    end
    $finish;
  end

endmodule
